/* hw/rtl/vajl_pkg.sv */
// shared types, constants and helper functions for the velocity limiter
package vajl_pkg;

  localparam int DATA_W    = 24;
  localparam int DIV_STEPS = 24;

  localparam logic [DATA_W-1:0]        ALL_ONES = '1;
  localparam logic signed [DATA_W-1:0] SMAX     = 24'sh7FFFFF;
  localparam logic signed [DATA_W-1:0] SMIN     = 24'sh800000;
  localparam logic signed [DATA_W-1:0] ONE_Q16  = 24'sh010000;

  // register map, one 32-bit word per register
  typedef enum logic [2:0] {
    REG_VEL_FLOOR  = 3'd0,
    REG_VEL_CEIL   = 3'd1,
    REG_ACC_FLOOR  = 3'd2,
    REG_ACC_CEIL   = 3'd3,
    REG_DEC_FLOOR  = 3'd4,
    REG_DEC_CEIL   = 3'd5,
    REG_JERK_FLOOR = 3'd6,
    REG_JERK_CEIL  = 3'd7
  } vajl_reg_t;

  typedef struct packed {
    logic [DATA_W-1:0] vel_floor;
    logic [DATA_W-1:0] vel_ceil;
    logic [DATA_W-1:0] acc_floor;
    logic [DATA_W-1:0] acc_ceil;
    logic [DATA_W-1:0] dec_floor;
    logic [DATA_W-1:0] dec_ceil;
    logic [DATA_W-1:0] jerk_floor;
    logic [DATA_W-1:0] jerk_ceil;
  } vajl_cfg_t;

  // limited velocity plus the command it came from
  typedef struct packed {
    logic signed [DATA_W-1:0] speed;
    logic signed [DATA_W-1:0] cmd;
  } vajl_lim_t;

  // one divider stage
  typedef struct packed {
    logic [DATA_W-1:0]        rem;
    logic [DATA_W-1:0]        nlow;
    logic [DATA_W-1:0]        quo;
    logic [DATA_W-1:0]        div;
    logic                     neg;
    logic                     big;
    logic                     zero;
    logic signed [DATA_W-1:0] speed;
  } vajl_div_t;

  function automatic logic signed [DATA_W-1:0] sat24(input logic signed [27:0] x);
    logic signed [DATA_W-1:0] r;
    if (x > 28'sd8388607) begin
      r = SMAX;
    end else if (x < -28'sd8388608) begin
      r = SMIN;
    end else begin
      r = x[DATA_W-1:0];
    end
    return r;
  endfunction

  // ceiling test first, then floor
  function automatic logic [25:0] clamp_mag(input logic [25:0] m, input logic [25:0] lo,
                                            input logic [25:0] hi, input logic hi_on);
    logic [25:0] r;
    if (hi_on && (m > hi)) begin
      r = hi;
    end else if (m < lo) begin
      r = lo;
    end else begin
      r = m;
    end
    return r;
  endfunction

endpackage

/* hw/rtl/vajl_limit.sv */
// five-stage jerk, acceleration and velocity limiting pipeline
module vajl_limit (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     adv,
  input  vajl_pkg::vajl_cfg_t      cfg,
  input  logic                     in_valid,
  input  logic signed [23:0]       commanded_speed,
  input  logic signed [23:0]       previous_speed,
  input  logic signed [23:0]       older_speed,
  input  logic [15:0]              time_step,
  output logic                     out_valid,
  output vajl_pkg::vajl_lim_t      out_data
);
  import vajl_pkg::*;

  logic vld1, vld2, vld3, vld4, vld5;

  // stage 1: dt squared, first difference
  logic signed [23:0] cmd1, v0_1;
  logic signed [24:0] dv0_1;
  logic [15:0]        dt1;
  logic [31:0]        dtsq1;

  // stage 2: bounds, second difference
  logic signed [23:0] cmd2, v0_2;
  logic signed [24:0] dv0_2;
  logic signed [25:0] dd2;
  logic [24:0]        jlo2, jhi2;
  logic [23:0]        alo2, ahi2, dlo2, dhi2;

  // stage 3: after jerk limit
  logic signed [23:0] cmd3, v0_3, vj3;
  logic [23:0]        alo3, ahi3, dlo3, dhi3;

  // stage 4: after accel limit
  logic signed [23:0] cmd4, va4;

  // stage 5: after velocity limit
  logic signed [23:0] cmd5, vv5;

  logic [55:0] jlo_prod, jhi_prod;
  logic [39:0] alo_prod, ahi_prod, dlo_prod, dhi_prod;

  logic        jerk_on, acc_on, vel_on;
  logic [25:0] j_mag, j_b;
  logic signed [26:0] j_da;
  logic signed [27:0] j_sum;
  logic signed [23:0] vj_next;

  logic signed [24:0] a_d;
  logic [23:0]        a_magv, a_magv0;
  logic [25:0]        a_mag, a_lo, a_hi, a_b;
  logic               a_speeding, a_hi_on;
  logic signed [26:0] a_sd;
  logic signed [27:0] a_sum;
  logic signed [23:0] va_next;

  logic [25:0]        v_mag, v_b;
  logic signed [27:0] v_sv;
  logic signed [23:0] vv_next;

  assign jerk_on = cfg.jerk_ceil != ALL_ONES;
  assign acc_on  = cfg.acc_ceil  != ALL_ONES;
  assign vel_on  = cfg.vel_ceil  != ALL_ONES;

  assign jlo_prod = 56'(cfg.jerk_floor) * 56'(dtsq1);
  assign jhi_prod = 56'(cfg.jerk_ceil)  * 56'(dtsq1);
  assign alo_prod = 40'(cfg.acc_floor) * 40'(dt1);
  assign ahi_prod = 40'(cfg.acc_ceil)  * 40'(dt1);
  assign dlo_prod = 40'(cfg.dec_floor) * 40'(dt1);
  assign dhi_prod = 40'(cfg.dec_ceil)  * 40'(dt1);

  // jerk clamp
  always_comb begin
    j_mag   = dd2[25] ? 26'(-dd2) : 26'(dd2);
    j_b     = clamp_mag(j_mag, {1'b0, jlo2}, {1'b0, jhi2}, 1'b1);
    j_da    = dd2[25] ? -$signed({1'b0, j_b}) : $signed({1'b0, j_b});
    j_sum   = 28'(v0_2) + 28'(dv0_2) + 28'(j_da);
    vj_next = jerk_on ? sat24(j_sum) : cmd2;
  end

  // accel or decel clamp, picked by whether speed magnitude grows
  always_comb begin
    a_d        = 25'(vj3) - 25'(v0_3);
    a_magv     = vj3[23]  ? 24'(-25'(vj3))  : 24'(vj3);
    a_magv0    = v0_3[23] ? 24'(-25'(v0_3)) : 24'(v0_3);
    a_mag      = a_d[24]  ? 26'(-a_d) : 26'(a_d);
    a_speeding = a_magv >= a_magv0;
    a_lo       = a_speeding ? 26'(alo3) : 26'(dlo3);
    a_hi       = a_speeding ? 26'(ahi3) : 26'(dhi3);
    a_hi_on    = a_speeding || (cfg.dec_ceil != ALL_ONES);
    a_b        = clamp_mag(a_mag, a_lo, a_hi, a_hi_on);
    a_sd       = a_d[24] ? -$signed({1'b0, a_b}) : $signed({1'b0, a_b});
    a_sum      = 28'(v0_3) + 28'(a_sd);
    va_next    = acc_on ? sat24(a_sum) : vj3;
  end

  // velocity clamp
  always_comb begin
    v_mag   = va4[23] ? 26'(-25'(va4)) : 26'(va4);
    v_b     = clamp_mag(v_mag, 26'(cfg.vel_floor), 26'(cfg.vel_ceil), 1'b1);
    v_sv    = va4[23] ? -$signed({2'b0, v_b}) : $signed({2'b0, v_b});
    vv_next = vel_on ? sat24(v_sv) : va4;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
      vld2 <= 1'b0;
      vld3 <= 1'b0;
      vld4 <= 1'b0;
      vld5 <= 1'b0;
    end else if (adv) begin
      vld1 <= in_valid;
      vld2 <= vld1;
      vld3 <= vld2;
      vld4 <= vld3;
      vld5 <= vld4;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cmd1  <= commanded_speed;
      v0_1  <= previous_speed;
      dv0_1 <= 25'(previous_speed) - 25'(older_speed);
      dt1   <= time_step;
      dtsq1 <= 32'(time_step) * 32'(time_step);

      cmd2  <= cmd1;
      v0_2  <= v0_1;
      dv0_2 <= dv0_1;
      dd2   <= 26'(cmd1) - 26'(v0_1) - 26'(dv0_1);
      // times 2 and over 2^32 folds into over 2^31
      jlo2  <= jlo_prod[55:31];
      jhi2  <= jhi_prod[55:31];
      alo2  <= alo_prod[39:16];
      ahi2  <= ahi_prod[39:16];
      dlo2  <= dlo_prod[39:16];
      dhi2  <= dhi_prod[39:16];

      cmd3  <= cmd2;
      v0_3  <= v0_2;
      vj3   <= vj_next;
      alo3  <= alo2;
      ahi3  <= ahi2;
      dlo3  <= dlo2;
      dhi3  <= dhi2;

      cmd4  <= cmd3;
      va4   <= va_next;

      cmd5  <= cmd4;
      vv5   <= vv_next;
    end
  end

  assign out_valid      = vld5;
  assign out_data.speed = vv5;
  assign out_data.cmd   = cmd5;

endmodule

/* hw/rtl/vajl_div.sv */
// pipelined restoring divider for the output to command ratio, one bit per stage
module vajl_div (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  logic                 in_valid,
  input  vajl_pkg::vajl_lim_t  in_data,
  output logic                 out_valid,
  output logic signed [23:0]   out_speed,
  output logic signed [23:0]   out_ratio
);
  import vajl_pkg::*;

  vajl_div_t st   [0:DIV_STEPS];
  vajl_div_t step [0:DIV_STEPS-1];
  logic      vld  [0:DIV_STEPS];
  logic [24:0] trial [0:DIV_STEPS-1];

  vajl_div_t setup;
  logic [23:0] abs_v, abs_c;
  logic signed [23:0] ratio_next;
  logic [23:0] q;

  logic               fvld;
  logic signed [23:0] fspeed, fratio;

  // numerator is |v| * 2^16; quotient of 2^24 or more saturates (a zero command gives 1.0)
  always_comb begin
    abs_v       = in_data.speed[23] ? 24'(-25'(in_data.speed)) : 24'(in_data.speed);
    abs_c       = in_data.cmd[23]   ? 24'(-25'(in_data.cmd))   : 24'(in_data.cmd);
    setup.rem   = {8'b0, abs_v[23:8]};
    setup.nlow  = {abs_v[7:0], 16'b0};
    setup.quo   = '0;
    setup.div   = abs_c;
    setup.neg   = in_data.speed[23] ^ in_data.cmd[23];
    setup.big   = {8'b0, abs_v} >= {abs_c, 8'b0};
    setup.zero  = in_data.cmd == '0;
    setup.speed = in_data.speed;
  end

  always_comb begin
    for (int k = 0; k < DIV_STEPS; k++) begin
      trial[k]     = {st[k].rem, st[k].nlow[23]};
      step[k]      = st[k];
      step[k].nlow = {st[k].nlow[22:0], 1'b0};
      if (trial[k] >= {1'b0, st[k].div}) begin
        step[k].rem = 24'(trial[k] - {1'b0, st[k].div});
        step[k].quo = {st[k].quo[22:0], 1'b1};
      end else begin
        step[k].rem = trial[k][23:0];
        step[k].quo = {st[k].quo[22:0], 1'b0};
      end
    end
  end

  // sign and saturate the quotient, or give 1.0 for a zero command
  always_comb begin
    q = st[DIV_STEPS].quo;
    if (st[DIV_STEPS].zero) begin
      ratio_next = ONE_Q16;
    end else if (st[DIV_STEPS].neg) begin
      ratio_next = (st[DIV_STEPS].big || (q > 24'd8388608)) ? SMIN : $signed(~q + 24'd1);
    end else begin
      ratio_next = (st[DIV_STEPS].big || (q > 24'd8388607)) ? SMAX : $signed(q);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= DIV_STEPS; k++) begin
        vld[k] <= 1'b0;
      end
      fvld <= 1'b0;
    end else if (adv) begin
      vld[0] <= in_valid;
      for (int k = 1; k <= DIV_STEPS; k++) begin
        vld[k] <= vld[k-1];
      end
      fvld <= vld[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st[0] <= setup;
      for (int k = 1; k <= DIV_STEPS; k++) begin
        st[k] <= step[k-1];
      end
      fspeed <= st[DIV_STEPS].speed;
      fratio <= ratio_next;
    end
  end

  assign out_valid = fvld;
  assign out_speed = fspeed;
  assign out_ratio = fratio;

endmodule

/* hw/rtl/velocity_accel_jerk_limiter_core.sv */
// top level of the velocity limiter: register file, limiting pipeline, divider, output buffer
// Limits a commanded velocity by jerk, then acceleration (or deceleration when the
// speed magnitude shrinks), then velocity, and reports the limited velocity with its
// ratio to the command in signed Q8.16. One command enters per clock while in_stall is
// low; a result passes through five limiter stages, one divider setup stage, 24 one-bit
// divider stages, one ratio format stage and the output register. The divider stages
// make up most of that path. A one-beat skid register behind the output register lets
// the pipeline take one more result while the consumer stalls; once it fills, in_stall
// rises and the whole pipeline holds. Registers sit on the APB port at byte address
// 4*i and should be written only while no command is in flight. A ceiling register of
// all ones turns that limit off (the decel ceiling only drops its upper bound).
module velocity_accel_jerk_limiter_core (
  input  logic               clk,
  input  logic               rst,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // command channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [23:0] commanded_speed,
  input  logic signed [23:0] previous_speed,
  input  logic signed [23:0] older_speed,
  input  logic [15:0]        time_step,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [23:0] limited_speed,
  output logic signed [23:0] scale_ratio
);
  import vajl_pkg::*;

  vajl_cfg_t cfg;
  vajl_reg_t reg_sel;
  logic      cfg_wr;

  // pipeline moves whenever the skid beat is empty
  logic      adv;
  logic      lim_valid;
  vajl_lim_t lim_data;
  logic      div_valid;
  logic signed [23:0] div_speed, div_ratio;
  logic      incoming, out_free;

  logic               skid_valid;
  logic signed [23:0] skid_speed, skid_ratio;

  assign pready  = 1'b1;
  assign reg_sel = vajl_reg_t'(paddr[4:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  // register writes, only the low 24 bits are kept
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.vel_floor  <= '0;
      cfg.vel_ceil   <= ALL_ONES;
      cfg.acc_floor  <= '0;
      cfg.acc_ceil   <= ALL_ONES;
      cfg.dec_floor  <= '0;
      cfg.dec_ceil   <= ALL_ONES;
      cfg.jerk_floor <= '0;
      cfg.jerk_ceil  <= ALL_ONES;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_VEL_FLOOR:  cfg.vel_floor  <= pwdata[23:0];
        REG_VEL_CEIL:   cfg.vel_ceil   <= pwdata[23:0];
        REG_ACC_FLOOR:  cfg.acc_floor  <= pwdata[23:0];
        REG_ACC_CEIL:   cfg.acc_ceil   <= pwdata[23:0];
        REG_DEC_FLOOR:  cfg.dec_floor  <= pwdata[23:0];
        REG_DEC_CEIL:   cfg.dec_ceil   <= pwdata[23:0];
        REG_JERK_FLOOR: cfg.jerk_floor <= pwdata[23:0];
        REG_JERK_CEIL:  cfg.jerk_ceil  <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (reg_sel)
      REG_VEL_FLOOR:  prdata = {8'b0, cfg.vel_floor};
      REG_VEL_CEIL:   prdata = {8'b0, cfg.vel_ceil};
      REG_ACC_FLOOR:  prdata = {8'b0, cfg.acc_floor};
      REG_ACC_CEIL:   prdata = {8'b0, cfg.acc_ceil};
      REG_DEC_FLOOR:  prdata = {8'b0, cfg.dec_floor};
      REG_DEC_CEIL:   prdata = {8'b0, cfg.dec_ceil};
      REG_JERK_FLOOR: prdata = {8'b0, cfg.jerk_floor};
      REG_JERK_CEIL:  prdata = {8'b0, cfg.jerk_ceil};
      default:        prdata = '0;
    endcase
  end

  assign adv      = !skid_valid;
  assign in_stall = skid_valid;

  vajl_limit u_limit (
    .clk             (clk),
    .rst             (rst),
    .adv             (adv),
    .cfg             (cfg),
    .in_valid        (in_valid),
    .commanded_speed (commanded_speed),
    .previous_speed  (previous_speed),
    .older_speed     (older_speed),
    .time_step       (time_step),
    .out_valid       (lim_valid),
    .out_data        (lim_data)
  );

  vajl_div u_div (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (lim_valid),
    .in_data   (lim_data),
    .out_valid (div_valid),
    .out_speed (div_speed),
    .out_ratio (div_ratio)
  );

  // a beat leaves the pipeline only on an edge where it advances
  assign incoming = div_valid && adv;
  assign out_free = !out_valid || !out_stall;

  // output register with one skid beat behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid  <= incoming;
      end
    end else if (incoming) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        limited_speed <= skid_speed;
        scale_ratio   <= skid_ratio;
      end else begin
        limited_speed <= div_speed;
        scale_ratio   <= div_ratio;
      end
    end else if (incoming) begin
      skid_speed <= div_speed;
      skid_ratio <= div_ratio;
    end
  end

  // a full skid beat always has a result in front of it
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("skid beat held with no result in the output register");

  // one consumer beat drains the skid register
  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    (in_stall && !out_stall) |=> !in_stall)
    else $error("skid beat not drained after output was taken");

  // nothing comes out right after reset
  a_quiet_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result presented right after reset");

endmodule
